// ----- rtl/c2hks_pkg.sv -----
package c2hks_pkg;

	localparam int CharW   = 16;
	localparam int ModW    = 8;
	localparam int KeyW    = 7;
	localparam int DigitW  = 4;
	localparam int RptW    = 4;
	localparam int WeightW = 17;

	// modifier byte codes
	localparam logic [ModW-1:0] MOD_NONE   = 8'h00;
	localparam logic [ModW-1:0] MOD_RSHIFT = 8'h20;
	localparam logic [ModW-1:0] MOD_RALT   = 8'h40;

	// keypad keycodes
	localparam logic [KeyW-1:0] KP_ZERO_CODE  = 7'd98;
	localparam logic [KeyW-1:0] KP_DIGIT_BASE = 7'd88;
	localparam logic [KeyW-1:0] KEY_NONE      = 7'd0;

	// report positions inside an alt-code run
	localparam logic [RptW-1:0] RPT_FIRST     = 4'd0;
	localparam logic [RptW-1:0] RPT_PLAIN_END = 4'd1;
	localparam logic [RptW-1:0] RPT_LAST_PRESS = 4'd9;
	localparam logic [RptW-1:0] RPT_ALT_END   = 4'd11;
	localparam logic [RptW-1:0] RPT_SPLIT_MAX = 4'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_EMIT
	} state_t;

	// decimal place select: 0 = ten thousands .. 3 = tens
	typedef logic [1:0] place_t;

	typedef struct packed {
		logic             load;
		logic [CharW-1:0] value;
		logic             start;
		place_t           place;
	} split_ctrl_t;

	typedef struct packed {
		logic              busy;
		logic [DigitW-1:0] digit;
		logic [DigitW-1:0] rem_lo;
	} split_stat_t;

	function automatic logic [13:0] place_weight(input place_t p);
		logic [13:0] w;
		case (p)
			2'd0:    w = 14'd10000;
			2'd1:    w = 14'd1000;
			2'd2:    w = 14'd100;
			default: w = 14'd10;
		endcase
		return w;
	endfunction

	function automatic logic [KeyW-1:0] keypad_code(input logic [DigitW-1:0] d);
		logic [KeyW-1:0] k;
		if (d == '0) begin
			k = KP_ZERO_CODE;
		end else begin
			k = KP_DIGIT_BASE + {3'b000, d};
		end
		return k;
	endfunction

endpackage

// ----- rtl/c2hks_digit_unit.sv -----
module c2hks_digit_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  c2hks_pkg::split_ctrl_t ctrl,
	output c2hks_pkg::split_stat_t stat
);
	import c2hks_pkg::*;

	logic [CharW-1:0]   rem_q;
	logic [WeightW-1:0] weight_q;
	logic [DigitW-1:0]  digit_q;
	logic [1:0]         step_q;
	logic               busy_q;

	logic               ge;
	logic [WeightW-1:0] diff;

	// shared compare and subtract
	assign diff = {1'b0, rem_q} - weight_q;
	assign ge   = ({1'b0, rem_q} >= weight_q);

	// control: four binary-weighted steps per digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			if (step_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: remainder, trial weight, digit bits msb first
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= ctrl.value;
		end else if (busy_q && ge) begin
			rem_q <= diff[CharW-1:0];
		end
		if (ctrl.start) begin
			weight_q <= {place_weight(ctrl.place), 3'b000};
			digit_q  <= '0;
		end else if (busy_q) begin
			weight_q <= weight_q >> 1;
			digit_q  <= {digit_q[DigitW-2:0], ge};
		end
	end

	assign stat.busy   = busy_q;
	assign stat.digit  = digit_q;
	assign stat.rem_lo = rem_q[DigitW-1:0];

endmodule

// ----- rtl/char_to_hid_keystroke_sequence_unit.sv -----
// channel   dir   tdata                             tuser   tlast
// s_axis    in    [15:0] char_code                  -       -
// m_axis    out   [7:0] modifier_byte, [14:8] key   -       last_report
//
// a zero word is accepted and gives no report.
// a plain key gives two reports, a press and then a release.
// an alt-code word gives twelve reports; each of its first four digits takes four compare/subtract
// steps in the digit unit before the sequencer goes back to emit.
// s_axis_tready is high only between characters; m_axis stalls hold the sequencer.
// arst_n clears the sequencer and the output valid.
module char_to_hid_keystroke_sequence_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] char_code
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] modifier_byte, [14:8] key_code, [15] zero
	output logic        m_axis_tlast   // last_report
);
	import c2hks_pkg::*;

	state_t          state_q, state_d;
	logic [RptW-1:0] rpt_q, rpt_d;
	logic            plain_q, plain_d;
	logic [7:0]      lo_q;

	logic            out_valid_q;
	logic [ModW-1:0] out_mod_q;
	logic [KeyW-1:0] out_key_q;
	logic            out_last_q;

	logic            slot_free;
	logic            emit;
	logic            accept;
	logic [ModW-1:0] rpt_mod;
	logic [KeyW-1:0] rpt_key;
	logic            rpt_last;
	logic [DigitW-1:0] press_digit;

	split_ctrl_t split_ctrl;
	split_stat_t split_stat;

	c2hks_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (split_ctrl),
		.stat   (split_stat)
	);

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// report contents for the current position
	always_comb begin
		press_digit = (rpt_q == RPT_LAST_PRESS) ? split_stat.rem_lo : split_stat.digit;
		rpt_mod  = MOD_NONE;
		rpt_key  = KEY_NONE;
		rpt_last = 1'b0;
		if (plain_q) begin
			if (rpt_q == RPT_FIRST) begin
				rpt_mod = lo_q[7] ? MOD_RSHIFT : MOD_NONE;
				rpt_key = lo_q[KeyW-1:0];
			end else begin
				rpt_last = 1'b1;
			end
		end else if (rpt_q == RPT_ALT_END) begin
			rpt_last = 1'b1;
		end else begin
			rpt_mod = MOD_RALT;
			if (rpt_q[0]) begin
				rpt_key = keypad_code(press_digit);
			end
		end
	end

	// sequencer next state
	always_comb begin
		state_d          = state_q;
		rpt_d            = rpt_q;
		plain_d          = plain_q;
		emit             = 1'b0;
		split_ctrl.load  = 1'b0;
		split_ctrl.value = s_axis_tdata;
		split_ctrl.start = 1'b0;
		split_ctrl.place = rpt_q[2:1];
		case (state_q)
			ST_IDLE: begin
				if (accept && (s_axis_tdata != '0)) begin
					split_ctrl.load = 1'b1;
					plain_d         = (s_axis_tdata[15:8] == 8'h00);
					rpt_d           = RPT_FIRST;
					state_d         = ST_EMIT;
				end
			end
			ST_SPLIT: begin
				if (!split_stat.busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit  = 1'b1;
					rpt_d = rpt_q + 4'd1;
					if ((plain_q && rpt_q == RPT_PLAIN_END) ||
					    (!plain_q && rpt_q == RPT_ALT_END)) begin
						state_d = ST_IDLE;
					end else if (!plain_q && !rpt_q[0] && rpt_q <= RPT_SPLIT_MAX) begin
						// next report is a digit press for the first four places
						split_ctrl.start = 1'b1;
						state_d          = ST_SPLIT;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rpt_q   <= '0;
			plain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rpt_q   <= rpt_d;
			plain_q <= plain_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= s_axis_tdata[7:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_mod_q  <= rpt_mod;
			out_key_q  <= rpt_key;
			out_last_q <= rpt_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_key_q, out_mod_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import c2hks_pkg::*;

	localparam int IdleLimit = 2000;
	localparam int TailCycles = 60;
	localparam int RandomChars = 138;

	typedef struct packed {
		logic [ModW-1:0] modifier;
		logic [KeyW-1:0] key;
		logic            last;
	} hid_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;

	logic [CharW-1:0] pending_chars[$];
	hid_report_t      expected_reports[$];
	int               mismatch_count = 0;
	int               src_gap = 0;
	bit               src_calm = 1'b0;
	int               snk_hold = 0;
	bit               snk_calm = 1'b0;
	int               idle_cycles = 0;

	char_to_hid_keystroke_sequence_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	task automatic report(input string what, input int exp_val, input int got_val);
		$display("mismatch at %0t: %s expected %0h got %0h", $time, what, exp_val, got_val);
		mismatch_count++;
	endtask

	function automatic void push_report(input logic [ModW-1:0] modifier,
			input logic [KeyW-1:0] key, input logic last);
		hid_report_t r;
		r.modifier = modifier;
		r.key = key;
		r.last = last;
		expected_reports.push_back(r);
	endfunction

	// expected hid reports for one character word
	function automatic void predict_keystrokes(input logic [CharW-1:0] word);
		int unsigned value;
		int unsigned digits[5];
		logic [KeyW-1:0] pad_key;
		value = {16'h0000, word};
		if (word[15:8] == 8'h00) begin
			// plain key: press then release, nothing for a zero word
			if (word[7:0] != 8'h00) begin
				push_report(word[7] ? MOD_RSHIFT : MOD_NONE, word[6:0], 1'b0);
				push_report(MOD_NONE, KEY_NONE, 1'b1);
			end
		end else begin
			// five-digit alt-code, most significant digit first
			for (int i = 4; i > 0; i--) begin
				digits[i] = value % 10;
				value = value / 10;
			end
			digits[0] = value;
			push_report(MOD_RALT, KEY_NONE, 1'b0);
			for (int i = 0; i < 5; i++) begin
				pad_key = (digits[i] == 0) ? KP_ZERO_CODE : KP_DIGIT_BASE + KeyW'(digits[i]);
				push_report(MOD_RALT, pad_key, 1'b0);
				push_report(MOD_RALT, KEY_NONE, 1'b0);
			end
			push_report(MOD_NONE, KEY_NONE, 1'b1);
		end
	endfunction

	// source side: one character per item, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			src_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (src_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (pending_chars.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_chars.pop_front();
				if ($urandom_range(0, 15) == 0) begin
					src_calm = !src_calm;
				end
				src_gap <= src_calm ? 0 : int'($urandom_range(0, 6));
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// sink side: after each report hold ready low for a random number of cycles
	always @(posedge clk or negedge arst_n) begin
		int draw;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_hold <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if ($urandom_range(0, 15) == 0) begin
				snk_calm = !snk_calm;
			end
			draw = snk_calm ? 0 : int'($urandom_range(0, 6));
			snk_hold <= draw;
			m_axis_tready <= (draw == 0);
		end else if (snk_hold != 0) begin
			snk_hold <= snk_hold - 1;
			m_axis_tready <= (snk_hold == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor: predict on accepted characters, check each accepted report
	always @(posedge clk) begin
		hid_report_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_keystrokes(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_reports.size() == 0) begin
					report("unexpected report", 0, int'(m_axis_tdata));
				end else begin
					want = expected_reports.pop_front();
					if (m_axis_tdata[7:0] != want.modifier) begin
						report("modifier_byte", int'(want.modifier), int'(m_axis_tdata[7:0]));
					end
					if (m_axis_tdata[14:8] != want.key) begin
						report("key_code", int'(want.key), int'(m_axis_tdata[14:8]));
					end
					if (m_axis_tlast != want.last) begin
						report("last_report", int'(want.last), int'(m_axis_tlast));
					end
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IdleLimit) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		logic [CharW-1:0] word;
		int pick;
		// directed: zero word, plain key extremes, shift bit, alt-code extremes
		pending_chars.push_back(16'h0000);
		pending_chars.push_back(16'h0001);
		pending_chars.push_back(16'h0004);
		pending_chars.push_back(16'h007F);
		pending_chars.push_back(16'h0080);
		pending_chars.push_back(16'h00FF);
		pending_chars.push_back(16'h00AA);
		pending_chars.push_back(16'h0055);
		pending_chars.push_back(16'h0000);
		pending_chars.push_back(16'h0100);
		pending_chars.push_back(16'h01FF);
		pending_chars.push_back(16'h2710);
		pending_chars.push_back(16'h270F);
		pending_chars.push_back(16'hEA60);
		pending_chars.push_back(16'hFFFF);
		pending_chars.push_back(16'h8000);
		pending_chars.push_back(16'h7FFF);
		pending_chars.push_back(16'h3039);
		pending_chars.push_back(16'hD431);
		pending_chars.push_back(16'h0000);
		pending_chars.push_back(16'hAAAA);
		pending_chars.push_back(16'h5555);
		// random mix of zero words, plain keys and alt-codes
		for (int i = 0; i < RandomChars; i++) begin
			pick = $urandom_range(0, 19);
			word = CharW'($urandom_range(0, 16'hFFFF));
			if (pick == 0) begin
				word = 16'h0000;
			end else if (pick <= 8) begin
				word[15:8] = 8'h00;
			end
			pending_chars.push_back(word);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// drain stimulus and outstanding reports
		while (pending_chars.size() != 0 || s_axis_tvalid || expected_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (TailCycles) @(posedge clk);

		if (mismatch_count == 0 && expected_reports.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
